[hw/rtl/sbct_pkg.sv]
package sbct_pkg;

    localparam int AXES       = 3;
    localparam int CW         = 32;   // coordinate and displacement width
    localparam int HW         = 20;   // half size register width
    localparam int GW         = 34;   // signed gap width
    localparam int MW         = 33;   // gap magnitude width
    localparam int DW         = 32;   // divisor magnitude width
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    localparam logic [HW-1:0] HALF_RESET = HW'(32768);

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef enum logic [1:0] {
        REG_HALF_X = 2'd0,
        REG_HALF_Y = 2'd1,
        REG_HALF_Z = 2'd2
    } t_reg_idx;

    // per-axis flags that ride along with the entry-time division
    typedef struct packed {
        logic qneg;   // quotient negative
        logic st;     // stationary axis
        logic blk;    // stationary axis without strict overlap
        logic dpos;   // displacement positive
    } t_side;

endpackage

[hw/rtl/sbct_front.sv]
module sbct_front
    import sbct_pkg::*;
#(
    parameter int TF = 16
) (
    input  logic                 i_clk,
    input  logic [1:0]           i_en,
    input  logic signed [CW-1:0] i_center,
    input  logic signed [CW-1:0] i_disp,
    input  logic signed [CW-1:0] i_smin,
    input  logic signed [CW-1:0] i_smax,
    input  logic [HW-1:0]        i_half,
    output logic [MW+TF-1:0]     o_num_in,
    output logic [MW+TF-1:0]     o_num_out,
    output logic [DW-1:0]        o_den,
    output t_side                o_side_in,
    output logic                 o_qneg_out
);

    localparam int NW = MW + TF;

    logic signed [GW-1:0] c_e, h_e, n_ga, n_gb;
    logic signed [GW-1:0] r_ga, r_gb;
    logic signed [CW-1:0] r_d;

    logic                 dpos, st, blk;
    logic signed [GW-1:0] gin, gout, ain, aout;
    logic [NW-1:0]        n_num_in, n_num_out;
    logic [DW-1:0]        n_den;
    t_side                n_side_in;
    logic                 n_qneg_out;

    logic [NW-1:0] r_num_in, r_num_out;
    logic [DW-1:0] r_den;
    t_side         r_side_in;
    logic          r_qneg_out;

    // gap from the mover's max face to the static min face (ga) and from its min face to the static max face (gb)
    always_comb begin
        c_e  = GW'(i_center);
        h_e  = GW'(i_half);
        n_ga = GW'(i_smin) - (c_e + h_e);
        n_gb = GW'(i_smax) - (c_e - h_e);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ga <= n_ga;
            r_gb <= n_gb;
            r_d  <= i_disp;
        end
    end

    always_comb begin
        dpos = !r_d[CW-1] && (r_d != '0);
        st   = (r_d == '0);
        blk  = !r_ga[GW-1] || r_gb[GW-1] || (r_gb == '0);
        gin  = dpos ? r_ga : r_gb;
        gout = dpos ? r_gb : r_ga;
        ain  = gin[GW-1] ? -gin : gin;
        aout = gout[GW-1] ? -gout : gout;
        n_num_in  = {ain[MW-1:0], {TF{1'b0}}};
        n_num_out = {aout[MW-1:0], {TF{1'b0}}};
        n_den     = r_d[CW-1] ? DW'(-r_d) : DW'(r_d);
        n_side_in.qneg = gin[GW-1] ^ r_d[CW-1];
        n_side_in.st   = st;
        n_side_in.blk  = st && blk;
        n_side_in.dpos = dpos;
        n_qneg_out     = gout[GW-1] ^ r_d[CW-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_num_in   <= n_num_in;
            r_num_out  <= n_num_out;
            r_den      <= n_den;
            r_side_in  <= n_side_in;
            r_qneg_out <= n_qneg_out;
        end
    end

    assign o_num_in   = r_num_in;
    assign o_num_out  = r_num_out;
    assign o_den      = r_den;
    assign o_side_in  = r_side_in;
    assign o_qneg_out = r_qneg_out;

endmodule

[hw/rtl/sbct_div.sv]
module sbct_div
    import sbct_pkg::*;
#(
    parameter int NW = 49,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem,
    output logic [SW-1:0] o_side
);

    // one quotient bit per stage, restoring long division
    logic [NW-1:0] r_w [NW];
    logic [DW-1:0] r_r [NW];
    logic [DW-1:0] r_d [NW];
    logic [SW-1:0] r_s [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DW-1:0] rem_i, den_i, n_rem;
        logic [NW-1:0] w_i;
        logic [SW-1:0] s_i;
        logic [DW:0]   t, diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_i = '0;
            assign den_i = i_den;
            assign w_i   = i_num;
            assign s_i   = i_side;
        end else begin : g_next
            assign rem_i = r_r[k-1];
            assign den_i = r_d[k-1];
            assign w_i   = r_w[k-1];
            assign s_i   = r_s[k-1];
        end

        always_comb begin
            t     = {rem_i, w_i[NW-1]};
            diff  = t - {1'b0, den_i};
            ge    = !diff[DW];
            n_rem = ge ? diff[DW-1:0] : t[DW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_r[k] <= n_rem;
                r_w[k] <= {w_i[NW-2:0], ge};
                r_d[k] <= den_i;
                r_s[k] <= s_i;
            end
        end
    end

    assign o_quo  = r_w[NW-1];
    assign o_rem  = r_r[NW-1];
    assign o_side = r_s[NW-1];

endmodule

[hw/rtl/sbct_resolve.sv]
module sbct_resolve
    import sbct_pkg::*;
#(
    parameter int TF = 16
) (
    input  logic               i_clk,
    input  logic [2:0]         i_en,
    input  logic [MW+TF-1:0]   i_quo_in  [AXES],
    input  logic [DW-1:0]      i_rem_in  [AXES],
    input  t_side              i_side_in [AXES],
    input  logic [MW+TF-1:0]   i_quo_out [AXES],
    input  logic [DW-1:0]      i_rem_out [AXES],
    input  logic               i_qneg_out [AXES],
    output logic               o_hit,
    output logic [TF+1:0]      o_time,
    output t_axis              o_axis,
    output logic               o_pos
);

    localparam int NW = MW + TF;
    localparam int TW = NW + 2;
    localparam logic signed [TW-1:0] ONE      = TW'(1) << TF;
    localparam logic signed [TW-1:0] FAR_NEG  = {1'b1, {(TW-1){1'b0}}};
    localparam logic signed [TW-1:0] FAR_POS  = {1'b0, {(TW-1){1'b1}}};

    function automatic logic signed [TW-1:0] floor_q(input logic [NW-1:0] quo,
                                                     input logic [DW-1:0] rem,
                                                     input logic          neg);
        logic signed [TW-1:0] mag;
        mag = TW'(quo);
        floor_q = neg ? -(mag + TW'(rem != '0)) : mag;
    endfunction

    logic signed [TW-1:0] n_tin [AXES];
    logic signed [TW-1:0] n_tout [AXES];
    logic signed [TW-1:0] r_tin [AXES];
    logic signed [TW-1:0] r_tout [AXES];
    logic [AXES-1:0]      r_blk, r_dpos;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_tin[a]  = i_side_in[a].st ? FAR_NEG :
                        floor_q(i_quo_in[a], i_rem_in[a], i_side_in[a].qneg);
            n_tout[a] = i_side_in[a].st ? FAR_POS :
                        floor_q(i_quo_out[a], i_rem_out[a], i_qneg_out[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int a = 0; a < AXES; a++) begin
                r_tin[a]  <= n_tin[a];
                r_tout[a] <= n_tout[a];
                r_blk[a]  <= i_side_in[a].blk;
                r_dpos[a] <= i_side_in[a].dpos;
            end
        end
    end

    // latest entry, earliest exit, contact axis with ties to x then y
    logic signed [TW-1:0] n_enter, n_leave, r_enter, r_leave;
    t_axis                n_axis, r_axis;
    logic                 r_blk_any, r_pos;

    always_comb begin
        n_enter = r_tin[0];
        if (r_tin[1] > n_enter) n_enter = r_tin[1];
        if (r_tin[2] > n_enter) n_enter = r_tin[2];
        n_leave = r_tout[0];
        if (r_tout[1] < n_leave) n_leave = r_tout[1];
        if (r_tout[2] < n_leave) n_leave = r_tout[2];
        if (r_tin[0] >= r_tin[1] && r_tin[0] >= r_tin[2]) n_axis = AXIS_X;
        else if (r_tin[1] >= r_tin[0] && r_tin[1] >= r_tin[2]) n_axis = AXIS_Y;
        else n_axis = AXIS_Z;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_enter   <= n_enter;
            r_leave   <= n_leave;
            r_axis    <= n_axis;
            r_blk_any <= |r_blk;
            r_pos     <= !r_dpos[n_axis];
        end
    end

    logic                 hit;
    logic signed [TW-1:0] t_sat;
    logic                 r_hit, r_pos_o;
    logic [TF+1:0]        r_time;
    t_axis                r_axis_o;

    always_comb begin
        hit   = !r_blk_any && (r_enter < r_leave) && (r_enter < ONE)
                && (r_leave > TW'(0));
        t_sat = (r_enter < -ONE) ? -ONE : r_enter;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_hit    <= hit;
            r_time   <= hit ? t_sat[TF+1:0] : ONE[TF+1:0];
            r_axis_o <= hit ? r_axis : AXIS_X;
            r_pos_o  <= hit && r_pos;
        end
    end

    assign o_hit  = r_hit;
    assign o_time = r_time;
    assign o_axis = r_axis_o;
    assign o_pos  = r_pos_o;

endmodule

[hw/rtl/swept_box_contact_time.sv]
// throughput: one test per cycle while the output is not stalled; six long dividers, one quotient bit per stage
// each pipeline stage holds its item while the next one is full and stalled
// reset (synchronous, active low) clears all valid bits; half sizes go to 0.5
module swept_box_contact_time
    import sbct_pkg::*;
#(
    parameter int TIME_FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // s_tdata: mover_center_x/y/z, disp_x/y/z, static_min_x/y/z, static_max_x/y/z
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [12*CW-1:0]     s_tdata,
    // m_tdata: hit, contact_time, normal_axis, normal_positive, zero fill
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [((TIME_FRAC_BITS+6+7)/8)*8-1:0] m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    localparam int TF  = TIME_FRAC_BITS;
    localparam int NW  = MW + TF;
    localparam int NS  = NW + 5;
    localparam int OBW = ((TF + 6 + 7) / 8) * 8;

    // configuration
    logic [HW-1:0] r_half [AXES];
    t_reg_idx      widx;

    assign pready = 1'b1;
    assign widx   = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) r_half[a] <= HALF_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (widx)
                REG_HALF_X: r_half[0] <= pwdata[HW-1:0];
                REG_HALF_Y: r_half[1] <= pwdata[HW-1:0];
                REG_HALF_Z: r_half[2] <= pwdata[HW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (widx)
            REG_HALF_X: prdata = APB_DW'(r_half[0]);
            REG_HALF_Y: prdata = APB_DW'(r_half[1]);
            REG_HALF_Z: prdata = APB_DW'(r_half[2]);
            default:    prdata = '0;
        endcase
    end

    // valid bits and per-stage load enables; a stage loads when empty or moving on
    logic [NS-1:0] r_vld, en;

    assign en[NS-1] = !r_vld[NS-1] || m_tready;
    for (genvar k = 0; k < NS - 1; k++) begin : g_en
        assign en[k] = !r_vld[k] || en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= s_tvalid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = r_vld[NS-1];

    // per-axis front end and dividers
    logic [NW-1:0] quo_in [AXES], quo_out [AXES];
    logic [DW-1:0] rem_in [AXES], rem_out [AXES];
    t_side         side_q [AXES];
    logic          qneg_q [AXES];

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        logic [NW-1:0] num_in, num_out;
        logic [DW-1:0] den;
        t_side         side_in;
        logic          qneg_out;

        sbct_front #(.TF(TF)) u_front (
            .i_clk      (i_clk),
            .i_en       (en[1:0]),
            .i_center   (s_tdata[a*CW +: CW]),
            .i_disp     (s_tdata[(3+a)*CW +: CW]),
            .i_smin     (s_tdata[(6+a)*CW +: CW]),
            .i_smax     (s_tdata[(9+a)*CW +: CW]),
            .i_half     (r_half[a]),
            .o_num_in   (num_in),
            .o_num_out  (num_out),
            .o_den      (den),
            .o_side_in  (side_in),
            .o_qneg_out (qneg_out)
        );

        sbct_div #(.NW(NW), .SW($bits(t_side))) u_div_in (
            .i_clk  (i_clk),
            .i_en   (en[NW+1:2]),
            .i_num  (num_in),
            .i_den  (den),
            .i_side (side_in),
            .o_quo  (quo_in[a]),
            .o_rem  (rem_in[a]),
            .o_side (side_q[a])
        );

        sbct_div #(.NW(NW), .SW(1)) u_div_out (
            .i_clk  (i_clk),
            .i_en   (en[NW+1:2]),
            .i_num  (num_out),
            .i_den  (den),
            .i_side (qneg_out),
            .o_quo  (quo_out[a]),
            .o_rem  (rem_out[a]),
            .o_side (qneg_q[a])
        );
    end

    logic          hit, pos;
    logic [TF+1:0] ctime;
    t_axis         axis;

    sbct_resolve #(.TF(TF)) u_resolve (
        .i_clk      (i_clk),
        .i_en       (en[NS-1:NW+2]),
        .i_quo_in   (quo_in),
        .i_rem_in   (rem_in),
        .i_side_in  (side_q),
        .i_quo_out  (quo_out),
        .i_rem_out  (rem_out),
        .i_qneg_out (qneg_q),
        .o_hit      (hit),
        .o_time     (ctime),
        .o_axis     (axis),
        .o_pos      (pos)
    );

    assign m_tdata = OBW'({pos, axis, ctime, hit});

    localparam logic [TF+1:0] ONE_OUT = (TF+2)'(1) << TF;

    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !hit |-> ctime == ONE_OUT && axis == AXIS_X && !pos)
        else $error("miss result carries non-default fields");

    a_hit_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && hit |-> axis == AXIS_X || axis == AXIS_Y || axis == AXIS_Z)
        else $error("hit reports an undefined axis");

    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input held off without an output stall");

    a_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && hit |-> $signed(ctime) < $signed(ONE_OUT)
                            && $signed(ctime) >= -$signed(ONE_OUT))
        else $error("contact time outside [-1, 1)");

endmodule
